>>> src/running_kth_smallest_dual_heap_assert.svh
// Assertion macros used by the checker file.
`ifndef RUNNING_KTH_SMALLEST_DUAL_HEAP_ASSERT_SVH
`define RUNNING_KTH_SMALLEST_DUAL_HEAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RKTH_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RKTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rkth_pkg.sv
package rkth_pkg;

  localparam int unsigned KEY_W = 32;
  localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

  typedef enum logic {
    FN_ADD = 1'b0,
    FN_GET = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Operations broadcast to every cell of a chain.
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_HEAD  = 3'd1,
    OP_POP_HEAD   = 3'd2,
    OP_INSERT     = 3'd3,
    OP_POP_INSERT = 3'd4
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
  } ctl_t;

  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
  } slot_t;

endpackage

>>> src/rkth_in_if.sv
interface rkth_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

>>> src/rkth_out_if.sv
interface rkth_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] result_value;

  modport source (output valid, output status, output result_value, input ready);
  modport sink (input valid, input status, input result_value, output ready);
endinterface

>>> src/rkth_cell.sv
module rkth_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rkth_pkg::ctl_t  ctl_i,
  input  rkth_pkg::slot_t left_i,
  input  rkth_pkg::slot_t right_i,
  output rkth_pkg::slot_t slot_o
);
  import rkth_pkg::*;

  logic             occ_q, occ_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic             self_gt, left_gt, right_gt;

  // A free slot sorts after every key.
  assign self_gt  = !occ_q || (key_q > ctl_i.key);
  assign left_gt  = !left_i.occ || (left_i.key > ctl_i.key);
  assign right_gt = !right_i.occ || (right_i.key > ctl_i.key);

  always_comb begin
    occ_d = occ_q;
    key_d = key_q;
    unique case (ctl_i.op)
      OP_HOLD: begin
        occ_d = occ_q;
        key_d = key_q;
      end
      OP_PUSH_HEAD: begin
        occ_d = left_i.occ;
        key_d = left_i.key;
      end
      OP_POP_HEAD: begin
        occ_d = right_i.occ;
        key_d = right_i.key;
      end
      OP_INSERT: begin
        // keep keys not above the new key, place it at the first larger slot, shift the rest
        if (!self_gt) begin
          occ_d = occ_q;
          key_d = key_q;
        end else if (!left_gt) begin
          occ_d = 1'b1;
          key_d = ctl_i.key;
        end else begin
          occ_d = left_i.occ;
          key_d = left_i.key;
        end
      end
      OP_POP_INSERT: begin
        // drop the head, pull keys not above the new key down by one, place the new key behind them;
        // the head key is always below the new key here
        if (!right_gt) begin
          occ_d = right_i.occ;
          key_d = right_i.key;
        end else if (!self_gt) begin
          occ_d = 1'b1;
          key_d = ctl_i.key;
        end else begin
          occ_d = occ_q;
          key_d = key_q;
        end
      end
      default: begin
        occ_d = occ_q;
        key_d = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign slot_o = '{occ: occ_q, key: key_q};

endmodule

>>> src/rkth_chain.sv
module rkth_chain #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rkth_pkg::ctl_t  ctl_i,
  output rkth_pkg::slot_t head_o
);
  import rkth_pkg::*;

  slot_t slots  [DEPTH];
  slot_t left_s [DEPTH];
  slot_t right_s[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      // the head sees the incoming key as its left neighbor
      assign left_s[i] = '{occ: 1'b1, key: ctl_i.key};
    end else begin : g_mid_l
      assign left_s[i] = slots[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_s[i] = '{occ: 1'b0, key: '0};
    end else begin : g_mid_r
      assign right_s[i] = slots[i+1];
    end

    rkth_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .left_i  (left_s[i]),
      .right_i (right_s[i]),
      .slot_o  (slots[i])
    );
  end

  assign head_o = slots[0];

endmodule

>>> src/running_kth_smallest_dual_heap.sv
// Channel  Port   Dir  Payload
// request  req_i  in   func, value
// result   rsp_o  out  status, result_value
//
// One result per item lands in an output register.
// A chain that changes updates in the cycle of acceptance: all its cells act on the broadcast key at once.
// A new item is taken while the result register is empty or being drained.
// Reset clears the counts, the cell occupancy flags and the result register.
// No clearing pass after reset: the block takes items in the first cycle.
module running_kth_smallest_dual_heap #(
  parameter int unsigned CAPACITY = 1024
) (
  input logic       clk_i,
  input logic       rst_ni,
  rkth_in_if.sink   req_i,
  rkth_out_if.source rsp_o
);
  import rkth_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Lower chain holds inverted keys so both chains sort ascending.
  logic [CW-1:0]    lcnt_q, lcnt_d, ucnt_q, ucnt_d;
  logic [CW:0]      total;
  logic             full, accept;
  logic [KEY_W-1:0] ukey_in, lmax_ukey;
  ctl_t             lctl, uctl;
  slot_t            lhead, uhead;

  logic             out_vld_q, out_vld_d;
  status_e          status_q, status_d;
  logic [KEY_W-1:0] res_q, res_d;

  assign req_i.ready = !out_vld_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign ukey_in   = req_i.value ^ SIGN_FLIP;
  assign lmax_ukey = ~lhead.key;
  assign total     = {1'b0, lcnt_q} + {1'b0, ucnt_q};
  assign full      = total >= (CW+1)'(CAPACITY);

  always_comb begin
    lctl     = '{op: OP_HOLD, key: ~ukey_in};
    uctl     = '{op: OP_HOLD, key: ukey_in};
    lcnt_d   = lcnt_q;
    ucnt_d   = ucnt_q;
    status_d = status_q;
    res_d    = res_q;
    if (accept) begin
      res_d = '0;
      if (req_i.func == FN_ADD) begin
        if (full) begin
          status_d = ST_FULL;
        end else if (lcnt_q != '0 && ukey_in < lmax_ukey) begin
          // lower top moves up, new value takes its place below
          uctl     = '{op: OP_PUSH_HEAD, key: lmax_ukey};
          lctl     = '{op: OP_POP_INSERT, key: ~ukey_in};
          ucnt_d   = ucnt_q + 1'b1;
          status_d = ST_ADDED;
        end else begin
          uctl     = '{op: OP_INSERT, key: ukey_in};
          ucnt_d   = ucnt_q + 1'b1;
          status_d = ST_ADDED;
        end
      end else begin
        if (ucnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          uctl     = '{op: OP_POP_HEAD, key: uhead.key};
          lctl     = '{op: OP_PUSH_HEAD, key: ~uhead.key};
          lcnt_d   = lcnt_q + 1'b1;
          ucnt_d   = ucnt_q - 1'b1;
          res_d    = uhead.key ^ SIGN_FLIP;
          status_d = ST_VALUE;
        end
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (accept) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q    <= '0;
      ucnt_q    <= '0;
      out_vld_q <= 1'b0;
      status_q  <= ST_ADDED;
      res_q     <= '0;
    end else begin
      lcnt_q    <= lcnt_d;
      ucnt_q    <= ucnt_d;
      out_vld_q <= out_vld_d;
      status_q  <= status_d;
      res_q     <= res_d;
    end
  end

  rkth_chain #(
    .DEPTH (CAPACITY)
  ) u_lower (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lctl),
    .head_o (lhead)
  );

  rkth_chain #(
    .DEPTH (CAPACITY)
  ) u_upper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (uctl),
    .head_o (uhead)
  );

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.result_value = res_q;

endmodule

>>> src/rkth_checker.sv
`include "running_kth_smallest_dual_heap_assert.svh"

module rkth_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] result_value_i
);
  import rkth_pkg::*;

  // hold a stalled result
  `RKTH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(result_value_i), "stalled result changed")

  // every accepted item shows a result in the next cycle
  `RKTH_ASSERT_NEXT(a_item_result, clk_i, rst_ni, in_valid_i && in_ready_i, out_valid_i, "accepted item gave no result")

  // an empty result register never stalls the input
  `RKTH_ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !out_valid_i, in_ready_i, "input stalled with output free")

  // only a returned value carries a nonzero result
  `RKTH_ASSERT_IMPL(a_zero_res, clk_i, rst_ni, out_valid_i && status_i != ST_VALUE, result_value_i == '0, "nonzero result without value")

endmodule

bind running_kth_smallest_dual_heap rkth_checker u_rkth_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .result_value_i (rsp_o.result_value)
);

>>> verif/running_kth_smallest_dual_heap_tb.sv
`timescale 1ns / 100ps

module running_kth_smallest_dual_heap_tb;
  import rkth_pkg::*;

  localparam int unsigned HEAP_CAP = 1024;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned OVERFLOW_DROPS = 24;
  localparam int unsigned TAIL_GETS = 16;

  typedef logic signed [31:0] key_t;

  localparam key_t KEY_MAX = 32'sh7fff_ffff;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  typedef struct {
    status_e status;
    key_t    value;
  } kth_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rkth_in_if  req_if ();
  rkth_out_if rsp_if ();

  running_kth_smallest_dual_heap #(.CAPACITY(HEAP_CAP)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Both kept ascending: every handed-out value is <= every remaining one.
  key_t        handed_out[$];
  key_t        remaining[$];
  kth_result_t expected_results[$];

  bit          quiet = 1'b0;
  bit          request_held = 1'b0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_wait = 0;
  int unsigned n_items = 0;
  int unsigned n_adds = 0;
  int unsigned n_gets = 0;
  int unsigned n_dropped = 0;
  int unsigned n_empty = 0;

  function automatic int slot_for(input key_t q[$], input key_t v);
    int idx;
    idx = q.size();
    while (idx > 0 && q[idx-1] > v) idx--;
    return idx;
  endfunction

  function automatic int unsigned stored_count();
    return handed_out.size() + remaining.size();
  endfunction

  function automatic kth_result_t predict_kth(func_e f, key_t v);
    kth_result_t r;
    key_t        top;
    r.value = '0;
    if (f == FN_ADD) begin
      if (stored_count() >= HEAP_CAP) begin
        r.status = ST_FULL;
      end else begin
        r.status = ST_ADDED;
        // A value equal to the handed-out maximum stays on the upper side.
        if (handed_out.size() > 0 && v < handed_out[$]) begin
          top = handed_out.pop_back();
          remaining.insert(slot_for(remaining, top), top);
          handed_out.insert(slot_for(handed_out, v), v);
        end else begin
          remaining.insert(slot_for(remaining, v), v);
        end
      end
    end else if (remaining.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_VALUE;
      r.value = remaining.pop_front();
      handed_out.push_back(r.value);
    end
    return r;
  endfunction

  function automatic key_t pick_value();
    case ($urandom_range(0, 9))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2, 3, 4: return key_t'($urandom);
      5, 6: return key_t'($urandom_range(0, 16)) - 8;
      7: return (handed_out.size() > 0) ? handed_out[$] : key_t'($urandom);
      8: return (handed_out.size() > 0 && handed_out[$] != KEY_MIN) ?
                handed_out[$] - 1 : key_t'($urandom);
      default: return (remaining.size() > 0) ? remaining[0] : key_t'($urandom);
    endcase
  endfunction

  task automatic send_item(func_e f, key_t v);
    int unsigned gap;
    kth_result_t r;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      if (request_held) req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= f;
    req_if.value <= v;
    request_held = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    r = predict_kth(f, v);
    expected_results.push_back(r);
    n_items++;
    if (f == FN_ADD) n_adds++;
    else n_gets++;
    if (r.status == ST_FULL) n_dropped++;
    if (r.status == ST_EMPTY) n_empty++;
  endtask

  task automatic release_request();
    if (request_held) begin
      req_if.valid <= 1'b0;
      request_held = 1'b0;
    end
  endtask

  task automatic wait_for_results();
    release_request();
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic test_empty_heap();
    send_item(FN_GET, KEY_MAX);
    send_item(FN_GET, KEY_MIN);
  endtask

  task automatic test_extreme_values();
    send_item(FN_ADD, KEY_MAX);
    send_item(FN_ADD, KEY_MIN);
    send_item(FN_ADD, 0);
    send_item(FN_ADD, -1);
    send_item(FN_ADD, 1);
    repeat (3) send_item(FN_GET, key_t'($urandom));
  endtask

  task automatic test_equal_and_below();
    send_item(FN_ADD, handed_out[$]);
    send_item(FN_ADD, -5);
    send_item(FN_ADD, KEY_MIN);
    send_item(FN_GET, 0);
    send_item(FN_ADD, handed_out[$]);
    send_item(FN_ADD, KEY_MAX);
  endtask

  task automatic test_drain_to_empty();
    while (remaining.size() > 0) send_item(FN_GET, key_t'($urandom));
    send_item(FN_GET, key_t'($urandom));
  endtask

  task automatic test_random_mix();
    int unsigned burst;
    while (stored_count() < HEAP_CAP - OVERFLOW_DROPS) begin
      quiet = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(4, 30);
      repeat (burst) send_item(FN_ADD, pick_value());
      if (remaining.size() <= 12 && $urandom_range(0, 5) == 0) begin
        repeat (remaining.size() + 1) send_item(FN_GET, key_t'($urandom));
      end else begin
        repeat ($urandom_range(0, 3)) send_item(FN_GET, key_t'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_capacity_overflow();
    while (n_dropped < OVERFLOW_DROPS) begin
      if ($urandom_range(0, 7) == 0) send_item(FN_GET, key_t'($urandom));
      else send_item(FN_ADD, pick_value());
    end
    repeat (TAIL_GETS) send_item(FN_GET, key_t'($urandom));
  endtask

  always @(posedge clk_i) begin : result_check
    kth_result_t exp_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d result_value %0d",
               rsp_if.status, rsp_if.result_value);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp_if.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.result_value !== exp_r.value) begin
          $error("result_value: expected %0d, actual %0d",
                 exp_r.value, rsp_if.result_value);
          error_count++;
        end
      end
      ready_wait = quiet ? 0 : $urandom_range(0, 9);
    end
    // Hold ready low for the drawn stall, then keep it high until the next item.
    if (ready_wait > 0) begin
      rsp_if.ready <= 1'b0;
      ready_wait--;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.func = FN_ADD;
    req_if.value = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_heap();
    test_extreme_values();
    test_equal_and_below();
    test_drain_to_empty();
    wait_for_results();
    test_random_mix();
    wait_for_results();
    test_capacity_overflow();

    release_request();
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d items: %0d adds (%0d dropped at capacity %0d), %0d gets (%0d on empty)",
             n_items, n_adds, n_dropped, HEAP_CAP, n_gets, n_empty);
    $display("Order statistics handed out: %0d, mismatches: %0d",
             handed_out.size(), error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/rkth_pkg.sv
src/rkth_in_if.sv
src/rkth_out_if.sv
src/rkth_cell.sv
src/rkth_chain.sv
src/running_kth_smallest_dual_heap.sv
src/rkth_checker.sv
verif/running_kth_smallest_dual_heap_tb.sv
